>>> rtl/bu_pkg.sv
package bu_pkg;

  // Store geometry and upscale factor
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int SCALE      = 3;

  // Fixed field widths
  localparam int COORD_W   = 11;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  // Compare width: holds coordinate + 1 and the largest store dimension
  localparam int DIM_MAX_W = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                             $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W     = (DIM_MAX_W > COORD_W + 1) ? DIM_MAX_W : COORD_W + 1;

  // Four banks interleaved on column and row parity
  localparam int BANK_COLS   = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS   = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH  = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ADDR_CALC_W = COORD_W + $clog2(BANK_COLS + 1) + 1;

  // Fraction and weight widths
  localparam int FRAC_W = (SCALE > 1) ? $clog2(SCALE) : 1;
  localparam int SC_W   = $clog2(SCALE + 1);
  localparam int WGT_W  = $clog2(SCALE * SCALE + 1);
  localparam int SUM_W  = $clog2(255 * SCALE * SCALE + 1);
  localparam int NUM_W  = $clog2(511 * SCALE * SCALE + 1);

  // Coordinate / SCALE by reciprocal multiply, exact for all 11-bit inputs
  localparam int QDIV_SH = COORD_W + 3;
  localparam int QDIV_M  = (2 ** QDIV_SH + SCALE - 1) / SCALE;
  localparam int QDIV_MW = QDIV_SH + 1;

  // Rounding divide by 2*SCALE^2, exact for all NUM_W-bit numerators
  localparam int RDIV_D  = 2 * SCALE * SCALE;
  localparam int RDIV_SH = NUM_W + 7;
  localparam int RDIV_M  = (2 ** RDIV_SH + RDIV_D - 1) / RDIV_D;
  localparam int RDIV_MW = RDIV_SH;

  // Command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  // par = {row parity, column parity} of the anchor pixel
  typedef struct packed {
    op_e                     op;
    logic                    wr_en;
    logic [1:0]              par;
    logic                    outside;
    logic [FRAC_W-1:0]       fx;
    logic [FRAC_W-1:0]       fy;
    logic [PIX_W-1:0]        pix;
    logic [3:0][BANK_AW-1:0] addr;
  } cmd_t;

endpackage

>>> rtl/bu_front.sv
module bu_front import bu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  op_e                op_i,
  input  logic [COORD_W-1:0] column_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic [CMP_W-1:0]   width_i,
  input  logic [CMP_W-1:0]   height_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  localparam logic [QDIV_MW-1:0]     QDIV_M_V    = QDIV_MW'(QDIV_M);
  localparam logic [SC_W-1:0]        SCALE_V     = SC_W'(SCALE);
  localparam logic [ADDR_CALC_W-1:0] BANK_COLS_V = ADDR_CALC_W'(BANK_COLS);

  logic                       accept;
  logic                       s1_valid_q, s1_valid_d;
  op_e                        op_q;
  logic [COORD_W-1:0]         col_q, row_q, qx_q, qy_q;
  logic [PIX_W-1:0]           pix_q;
  logic [COORD_W+QDIV_MW-1:0] prod_x, prod_y;

  logic [COORD_W-1:0]         x, y, xh0, xh1, yh0, yh1;
  logic [COORD_W:0]           x1, y1;
  logic [COORD_W+SC_W-1:0]    qsx, qsy;
  logic [COORD_W-1:0]         rx, ry;
  logic [ADDR_CALC_W-1:0]     base0, base1;
  logic [ADDR_CALC_W-1:0]     asum [4];

  assign busy_o = s1_valid_q & fifo_full_i;
  assign push_o = s1_valid_q & ~fifo_full_i;
  assign accept = start_i & ~busy_o;

  // quotient by reciprocal, registered before any further arithmetic
  assign prod_x = {{QDIV_MW{1'b0}}, column_i} * {{COORD_W{1'b0}}, QDIV_M_V};
  assign prod_y = {{QDIV_MW{1'b0}}, row_i} * {{COORD_W{1'b0}}, QDIV_M_V};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      col_q <= column_i;
      row_q <= row_i;
      pix_q <= pixel_i;
      qx_q  <= prod_x[QDIV_SH +: COORD_W];
      qy_q  <= prod_y[QDIV_SH +: COORD_W];
    end
  end

  // classify and build the bank command
  always_comb begin
    x    = (op_q == OP_QUERY) ? qx_q : col_q;
    y    = (op_q == OP_QUERY) ? qy_q : row_q;
    x1   = {1'b0, x} + (COORD_W + 1)'(1);
    y1   = {1'b0, y} + (COORD_W + 1)'(1);
    xh0  = x >> 1;
    yh0  = y >> 1;
    xh1  = x1[COORD_W:1];
    yh1  = y1[COORD_W:1];
    qsx  = {{SC_W{1'b0}}, qx_q} * {{COORD_W{1'b0}}, SCALE_V};
    qsy  = {{SC_W{1'b0}}, qy_q} * {{COORD_W{1'b0}}, SCALE_V};
    rx   = col_q - qsx[COORD_W-1:0];
    ry   = row_q - qsy[COORD_W-1:0];
    base0 = ADDR_CALC_W'(yh0) * BANK_COLS_V;
    base1 = ADDR_CALC_W'(yh1) * BANK_COLS_V;

    cmd_o.op      = op_q;
    cmd_o.pix     = pix_q;
    cmd_o.par     = {y[0], x[0]};
    cmd_o.fx      = rx[FRAC_W-1:0];
    cmd_o.fy      = ry[FRAC_W-1:0];
    cmd_o.wr_en   = (op_q == OP_LOAD) &&
                    (CMP_W'(col_q) < width_i) && (CMP_W'(row_q) < height_i);
    cmd_o.outside = (CMP_W'(x1) >= width_i) || (CMP_W'(y1) >= height_i);
    // bank whose parity matches the anchor takes the anchor half-coordinate
    for (int b = 0; b < 4; b++) begin
      asum[b] = ((y[0] == b[1]) ? base0 : base1) +
                ADDR_CALC_W'((x[0] == b[0]) ? xh0 : xh1);
      cmd_o.addr[b] = asum[b][BANK_AW-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !push_o |=> s1_valid_q && $stable(col_q) && $stable(op_q))
    else $error("front stage dropped a blocked command");
`endif

endmodule

>>> rtl/bu_cmd_fifo.sv
module bu_cmd_fifo import bu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty command queue");
`endif

endmodule

>>> rtl/bu_back.sv
module bu_back import bu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             done_o,
  output logic [PIX_W-1:0] value_o,
  output logic             outside_o
);

  localparam logic [SC_W-1:0]    SCALE_V  = SC_W'(SCALE);
  localparam logic [RDIV_MW-1:0] RDIV_M_V = RDIV_MW'(RDIV_M);
  localparam logic [NUM_W-1:0]   DEN_V    = NUM_W'(SCALE * SCALE);

  logic                       is_query, rd_en;
  logic [3:0]                 wr_en;
  logic [SC_W-1:0]            fx_e, fy_e, wx [2], wy [2];
  logic [2*SC_W-1:0]          wfull [4];

  logic [PIX_W-1:0]           rd_q [4];
  logic [WGT_W-1:0]           wgt_q [4];
  logic [PIX_W+WGT_W-1:0]     prod_q [4];
  logic [NUM_W-1:0]           num_q;
  logic [SUM_W-1:0]           sum;
  logic [NUM_W+RDIV_MW-1:0]   rprod;
  logic                       v1_q, v2_q, v3_q;
  logic                       out1_q, out2_q, out3_q;

  // the queue is drained every cycle; results cannot be held off
  assign pop_o    = valid_i;
  assign is_query = valid_i && (cmd_i.op == OP_QUERY);
  assign rd_en    = is_query && !cmd_i.outside;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      wr_en[b] = valid_i && (cmd_i.op == OP_LOAD) && cmd_i.wr_en && (cmd_i.par == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en[b]) begin
        mem[cmd_i.addr[b]] <= cmd_i.pix;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en) begin
        rd_q[b] <= mem[cmd_i.addr[b]];
      end
    end
  end

  // weight of each bank: bank parity xor anchor parity gives the neighbor offset
  always_comb begin
    fx_e  = SC_W'(cmd_i.fx);
    fy_e  = SC_W'(cmd_i.fy);
    wx[0] = SCALE_V - fx_e;
    wx[1] = fx_e;
    wy[0] = SCALE_V - fy_e;
    wy[1] = fy_e;
    for (int b = 0; b < 4; b++) begin
      wfull[b] = {{SC_W{1'b0}}, wx[b[0] ^ cmd_i.par[0]]} *
                 {{SC_W{1'b0}}, wy[b[1] ^ cmd_i.par[1]]};
    end
  end

  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    rprod = {{RDIV_MW{1'b0}}, num_q} * {{NUM_W{1'b0}}, RDIV_M_V};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= is_query;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out1_q <= cmd_i.outside;
    out2_q <= out1_q;
    out3_q <= out2_q;
    for (int b = 0; b < 4; b++) begin
      wgt_q[b]  <= wfull[b][WGT_W-1:0];
      prod_q[b] <= {{WGT_W{1'b0}}, rd_q[b]} * {{PIX_W{1'b0}}, wgt_q[b]};
    end
    num_q     <= NUM_W'({sum, 1'b0}) + DEN_V;
    value_o   <= out3_q ? '0 : rprod[RDIV_SH +: PIX_W];
    outside_o <= out3_q;
  end

`ifndef NO_ASSERTIONS
  a_query_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |-> ##4 done_o)
    else $error("query beat without result");
  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(is_query, 4))
    else $error("result without a query beat");
`endif

endmodule

>>> rtl/bilinear_upscaler.sv
// Integer-factor bilinear upscaler with an on-chip grey image store.
//
// Command channel: an item is taken at a rising edge with start high and
// busy low. operation_i = 0 loads pixel_i at (column_i, row_i); loads outside
// the configured image are dropped. operation_i = 1 queries output pixel
// (column_i, row_i) and produces exactly one result; loads produce none.
// Result channel: done_o is high for one cycle with value_o and outside_o.
// The receiver cannot stall it; done_o follows the accepting edge through the
// input register, queue, bank read, weighting, sum and rounding divide stages.
// Throughput is one item per cycle while busy is low: the four parity banks
// deliver the whole 2x2 neighborhood in one read. busy only rises when the
// command queue between the decode front end and the datapath is full.
// Config channel: cfg_index_i 0 writes image_width, 1 writes image_height;
// other indexes are ignored. cfg_ready_o is always high. Write only when idle.
// Reset clears the pipeline and queue and sets both dimensions to 512. The
// image store is not cleared; pixels must be loaded before they are queried.
module bilinear_upscaler import bu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation_i,
  input  logic [COORD_W-1:0]   column_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 done_o,
  output logic [PIX_W-1:0]     value_o,
  output logic                 outside_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [CMP_W-1:0] MAX_W_V = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MAX_H_V = CMP_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic [CMP_W-1:0] width_ext, height_ext, eff_width, eff_height;
  logic             push, pop, fifo_full, fifo_empty;
  cmd_t             cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(512);
      height_q <= CFG_W'(512);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // dimensions clipped to the store
  assign width_ext  = CMP_W'(width_q);
  assign height_ext = CMP_W'(height_q);
  assign eff_width  = (width_ext < MAX_W_V) ? width_ext : MAX_W_V;
  assign eff_height = (height_ext < MAX_H_V) ? height_ext : MAX_H_V;

  bu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .op_i        (op_e'(operation_i)),
    .column_i    (column_i),
    .row_i       (row_i),
    .pixel_i     (pixel_i),
    .width_i     (eff_width),
    .height_i    (eff_height),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  bu_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  bu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (!fifo_empty),
    .cmd_i     (cmd_out),
    .pop_o     (pop),
    .done_o    (done_o),
    .value_o   (value_o),
    .outside_o (outside_o)
  );

endmodule
